FILE: rtl/kcl_pkg.sv
// Shared types and constants of the keypad code lock.
`default_nettype none

package kcl_pkg;

    localparam int DIGIT_W     = 4;
    localparam int SHOWN_SLOTS = 10;
    localparam int SECRET_W    = DIGIT_W * SHOWN_SLOTS;
    localparam int FAIL_W      = 4;
    localparam int MODE_W      = 2;
    localparam int KEY_W       = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = SECRET_W;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_BITS    = MODE_W + FAIL_W + SECRET_W + DIGIT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [DIGIT_W-1:0]  BLANK_DIGIT     = 4'd15;
    localparam logic [KEY_W-1:0]    KEY_LAST_DIGIT  = 4'd9;
    localparam logic [KEY_W-1:0]    KEY_CLEAR       = 4'd10;
    localparam logic [KEY_W-1:0]    KEY_ENTER       = 4'd11;
    localparam logic [FAIL_W-1:0]   FAIL_SATURATE   = 4'd15;
    localparam logic [SECRET_W-1:0] SECRET_RESET    = 40'h5313126104;
    localparam logic [FAIL_W-1:0]   MAX_FAIL_RESET  = 4'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_SECRET_CODE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_FAILURES = 1'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENTRY  = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_LOCKED = 2'd2
    } kcl_mode_t;

    typedef struct packed {
        logic [DIGIT_W-1:0]  next_slot;
        logic [SECRET_W-1:0] shown_digits;
        logic [FAIL_W-1:0]   fail_count;
        logic [MODE_W-1:0]   mode;
    } kcl_result_t;

endpackage : kcl_pkg

`default_nettype wire

FILE: rtl/keypad_code_lock.sv
// Top level of the keypad code lock: stream ports, configuration and result register.
//
//  Channel | Direction | Transfer content
//  s_      | in        | tdata[3:0] key, tuser action
//  m_      | out       | tdata[1:0] mode, [5:2] fail_count, [45:6] shown_digits,
//          |           |   [49:46] next_slot
//  cfg_    | in        | register write, index 0 secret_code, 1 max_failures
//
// Each key event passes through the input register and then the result register, and one
// event is taken every cycle while the output is not stalled. The lock state is updated
// as an event moves from the input register to the result register. Reset blanks the entry
// slots and loads the default code and failure limit. A stalled output holds its result and
// the input register still takes one more event if it is empty.
`default_nettype none

module keypad_code_lock
    import kcl_pkg::*;
#(
    parameter int CODE_DIGITS = 10
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // key[3:0], zero padding
    input  wire logic                   s_tuser,   // action
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // mode, fail_count, shown_digits, next_slot
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                in_valid_reg;
    logic                in_action_reg;
    logic [KEY_W-1:0]    in_key_reg;
    logic                out_valid_reg;
    kcl_result_t         out_result_reg;
    kcl_result_t         result;
    logic [SECRET_W-1:0] secret_reg;
    logic [FAIL_W-1:0]   max_fail_reg;
    logic                advance;
    logic                step;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secret_reg   <= SECRET_RESET;
            max_fail_reg <= MAX_FAIL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SECRET_CODE:  secret_reg   <= cfg_data[SECRET_W-1:0];
                REG_MAX_FAILURES: max_fail_reg <= cfg_data[FAIL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= s_tuser;
            in_key_reg    <= s_tdata[KEY_W-1:0];
        end
        if (step)
            out_result_reg <= result;
    end

    kcl_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .action       (in_action_reg),
        .key          (in_key_reg),
        .secret_code  (secret_reg),
        .max_failures (max_fail_reg),
        .result       (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_result_reg};

endmodule : keypad_code_lock

`default_nettype wire

FILE: rtl/kcl_matcher.sv
// Parallel comparison of the entry slots with the configured code.
`default_nettype none

module kcl_matcher
    import kcl_pkg::*;
#(
    parameter int CODE_DIGITS = 10
)
(
    input  wire logic [CODE_DIGITS-1:0][DIGIT_W-1:0] slots,
    input  wire logic [SECRET_W-1:0]                 secret_code,
    output logic                                     match
);

    logic [CODE_DIGITS-1:0] hit;

    genvar s;
    generate
        for (s = 0; s < CODE_DIGITS; s++)
        begin : g_slot
            // Slots beyond the stored code compare against digit zero.
            if (s < SHOWN_SLOTS)
            begin : g_coded
                assign hit[s] = (slots[s] != BLANK_DIGIT) &&
                                (slots[s] == secret_code[s*DIGIT_W +: DIGIT_W]);
            end
            else
            begin : g_zero
                assign hit[s] = (slots[s] == '0);
            end
        end
    endgenerate

    assign match = &hit;

endmodule : kcl_matcher

`default_nettype wire

FILE: rtl/kcl_core.sv
// Lock state registers and the next-state logic for one key event.
`default_nettype none

module kcl_core
    import kcl_pkg::*;
#(
    parameter int CODE_DIGITS = 10
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                action,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [SECRET_W-1:0] secret_code,
    input  wire logic [FAIL_W-1:0]   max_failures,
    output kcl_result_t              result
);

    logic [CODE_DIGITS-1:0][DIGIT_W-1:0] slots_reg, slots_next;
    logic [DIGIT_W-1:0]                  slot_reg, slot_next;
    logic [FAIL_W-1:0]                   fail_reg, fail_next;
    kcl_mode_t                           mode_reg, mode_next;
    logic                                match;
    logic [DIGIT_W:0]                    slot_inc;
    logic [FAIL_W-1:0]                   fail_bumped;

    kcl_matcher #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_matcher (
        .slots       (slots_reg),
        .secret_code (secret_code),
        .match       (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= {CODE_DIGITS{BLANK_DIGIT}};
            slot_reg  <= '0;
            fail_reg  <= '0;
            mode_reg  <= MODE_ENTRY;
        end
        else if (step)
        begin
            slots_reg <= slots_next;
            slot_reg  <= slot_next;
            fail_reg  <= fail_next;
            mode_reg  <= mode_next;
        end
    end

    assign slot_inc    = {1'b0, slot_reg} + 5'd1;
    assign fail_bumped = (fail_reg < FAIL_SATURATE) ? fail_reg + 4'd1 : fail_reg;

    always_comb
    begin
        slots_next = slots_reg;
        slot_next  = slot_reg;
        fail_next  = fail_reg;
        mode_next  = mode_reg;
        unique case (mode_reg)
            MODE_ENTRY:
            begin
                if (!action)
                begin
                    if (key <= KEY_LAST_DIGIT)
                    begin
                        for (int s = 0; s < CODE_DIGITS; s++)
                        begin
                            if (slot_reg == DIGIT_W'(s))
                                slots_next[s] = key;
                        end
                        slot_next = (slot_inc >= (DIGIT_W+1)'(CODE_DIGITS)) ?
                                    '0 : slot_inc[DIGIT_W-1:0];
                    end
                    else if (key == KEY_CLEAR)
                    begin
                        slots_next = {CODE_DIGITS{BLANK_DIGIT}};
                        slot_next  = '0;
                    end
                    else if (key == KEY_ENTER)
                    begin
                        if (match)
                        begin
                            mode_next = MODE_OPEN;
                            slot_next = '0;
                        end
                        else
                        begin
                            fail_next  = fail_bumped;
                            slots_next = {CODE_DIGITS{BLANK_DIGIT}};
                            slot_next  = '0;
                            if (fail_bumped >= max_failures)
                                mode_next = MODE_LOCKED;
                        end
                    end
                end
            end
            MODE_OPEN:
            begin
                if (action)
                begin
                    slots_next = {CODE_DIGITS{BLANK_DIGIT}};
                    slot_next  = '0;
                    mode_next  = MODE_ENTRY;
                end
            end
            default:
            begin
                // Locked out: nothing changes until reset.
            end
        endcase
    end

    always_comb
    begin
        result              = '0;
        result.mode         = mode_next;
        result.fail_count   = fail_next;
        result.next_slot    = slot_next;
        for (int s = 0; s < SHOWN_SLOTS; s++)
        begin
            if (s < CODE_DIGITS)
                result.shown_digits[s*DIGIT_W +: DIGIT_W] = slots_next[s];
        end
    end

endmodule : kcl_core

`default_nettype wire
